// File: src/torsd_pkg.sv
// Shared types, register codes and arithmetic helpers for the torus distance core.
package torsd_pkg;

  localparam int SQRT_STEPS  = 32;
  localparam int DIV_T_STEPS = 32;
  localparam int DIV_V_STEPS = 33;
  localparam int CFG_INDEX_W = 4;
  localparam int PACK_W      = 54;
  localparam int COMP_W      = 18;

  localparam logic [PACK_W-1:0] AXIS_RESET     = 54'h10000000000000;
  localparam logic [PACK_W-1:0] FALLBACK_RESET = 54'h00000000010000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_AXIS,
    REG_FALLBACK,
    REG_MAJOR,
    REG_TUBE,
    REG_INWARD
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } query_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } result_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        q;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // round to nearest, ties up, drop 16 fraction bits
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    return (v + 66'sd32768) >>> 16;
  endfunction

  // one digit of the bitwise integer square root
  function automatic sqrt_t sqrt_step(input sqrt_t st, input int k);
    logic [63:0] bit_v;
    logic [63:0] trial;
    sqrt_t nx;
    bit_v = 64'd1 << (62 - 2 * k);
    trial = st.res + bit_v;
    nx = st;
    if (st.n >= trial) begin
      nx.n   = st.n - trial;
      nx.res = (st.res >> 1) + bit_v;
    end else begin
      nx.res = st.res >> 1;
    end
    return nx;
  endfunction

  // one quotient bit of restoring division
  function automatic div_t div_step(input logic [63:0] rem, input logic [31:0] den,
                                    input int sh);
    logic [65:0] dsh;
    div_t nx;
    dsh = {34'd0, den} << sh;
    nx.rem = rem;
    nx.q = 1'b0;
    if ({2'b00, rem} >= dsh) begin
      nx.rem = rem - dsh[63:0];
      nx.q = 1'b1;
    end
    return nx;
  endfunction

endpackage

// File: src/torus_signed_distance_core.sv
// Torus signed distance and distance vector, fully pipelined top level.
// Takes one query point per clock (busy never rises) and raises the one-cycle done strobe
// with its result once the point has passed every stage; the results cannot be held off.
// The pipeline is built from four bit-per-stage units in series: the radial-length
// and center-distance square roots, the core-distance root with the three radial
// divides, the core-offset root, and the three 33-bit vector divides. Configuration
// writes are always ready and must only be made while no point is in flight.
module torus_signed_distance_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  torsd_pkg::query_t                   query,
  output logic                                done,
  output torsd_pkg::result_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [torsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [torsd_pkg::PACK_W-1:0]        cfg_data
);
  import torsd_pkg::*;

  typedef struct {
    logic               v;
    sqrt_t              sr;
    sqrt_t              sc;
    logic signed [31:0] rv [3];
    logic signed [33:0] za [3];
    logic signed [31:0] z;
    logic signed [31:0] c [3];
  } pa_t;

  typedef struct {
    logic               v;
    sqrt_t              sq;
    logic [63:0]        rem [3];
    logic [31:0]        quot [3];
    logic               neg [3];
    logic [31:0]        r;
    logic [31:0]        cn;
    logic signed [31:0] rv [3];
    logic signed [33:0] za [3];
    logic signed [33:0] ft [3];
    logic signed [31:0] c [3];
  } pb_t;

  typedef struct {
    logic               v;
    sqrt_t              sq;
    logic signed [31:0] d [3];
    logic signed [33:0] s;
    logic signed [31:0] sdist;
    logic signed [31:0] c [3];
    logic [31:0]        cn;
  } pc_t;

  typedef struct {
    logic               v;
    logic [63:0]        rem [3];
    logic [32:0]        quot [3];
    logic               neg [3];
    logic [31:0]        den;
    logic               zero;
    logic signed [31:0] sdist;
  } pd_t;

  function automatic pa_t pa_step(input pa_t x, input int k);
    pa_t y;
    y = x;
    y.sr = sqrt_step(x.sr, k);
    y.sc = sqrt_step(x.sc, k);
    return y;
  endfunction

  function automatic pb_t pb_step(input pb_t x, input int k);
    pb_t y;
    div_t ds;
    y = x;
    y.sq = sqrt_step(x.sq, k);
    for (int i = 0; i < 3; i++) begin
      ds = div_step(x.rem[i], x.r, DIV_T_STEPS - 1 - k);
      y.rem[i] = ds.rem;
      y.quot[i] = {x.quot[i][DIV_T_STEPS-2:0], ds.q};
    end
    return y;
  endfunction

  function automatic pc_t pc_step(input pc_t x, input int k);
    pc_t y;
    y = x;
    y.sq = sqrt_step(x.sq, k);
    return y;
  endfunction

  function automatic pd_t pd_step(input pd_t x, input int k);
    pd_t y;
    div_t ds;
    y = x;
    for (int i = 0; i < 3; i++) begin
      ds = div_step(x.rem[i], x.den, DIV_V_STEPS - 1 - k);
      y.rem[i] = ds.rem;
      y.quot[i] = {x.quot[i][DIV_V_STEPS-2:0], ds.q};
    end
    return y;
  endfunction

  // configuration
  logic signed [31:0] center [3];
  logic [PACK_W-1:0]  axis_packed;
  logic [PACK_W-1:0]  fallback_packed;
  logic [30:0]        major_radius;
  logic [30:0]        tube_radius;
  logic               direction_inward;
  logic signed [COMP_W-1:0] ax [3];
  logic signed [COMP_W-1:0] fb [3];
  logic signed [31:0] qpos [3];

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      axis_packed <= AXIS_RESET;
      fallback_packed <= FALLBACK_RESET;
      major_radius <= '0;
      tube_radius <= '0;
      direction_inward <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center[0] <= cfg_data[31:0];
        REG_CENTER_Y: center[1] <= cfg_data[31:0];
        REG_CENTER_Z: center[2] <= cfg_data[31:0];
        REG_AXIS:     axis_packed <= cfg_data;
        REG_FALLBACK: fallback_packed <= cfg_data;
        REG_MAJOR:    major_radius <= cfg_data[30:0];
        REG_TUBE:     tube_radius <= cfg_data[30:0];
        REG_INWARD:   direction_inward <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = axis_packed[COMP_W*i +: COMP_W];
      fb[i] = fallback_packed[COMP_W*i +: COMP_W];
    end
    qpos[0] = query.pos_x;
    qpos[1] = query.pos_y;
    qpos[2] = query.pos_z;
  end

  // front end: offset, axial part, radial vector, squares
  logic               v1, v2, v3, v4, v5, v6;
  logic signed [31:0] c1 [3];
  logic signed [49:0] p2 [3];
  logic signed [31:0] c2 [3];
  logic signed [31:0] z3;
  logic signed [31:0] c3 [3];
  logic signed [49:0] zap4 [3];
  logic signed [31:0] z4;
  logic signed [31:0] c4 [3];
  logic signed [31:0] rv5 [3];
  logic signed [33:0] za5 [3];
  logic signed [31:0] z5;
  logic signed [31:0] c5 [3];
  logic [63:0]        rq6 [3];
  logic [63:0]        cq6 [3];
  logic signed [31:0] rv6 [3];
  logic signed [33:0] za6 [3];
  logic signed [31:0] z6;
  logic signed [31:0] c6 [3];
  logic signed [65:0] zr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zr[i] = rnd16(66'(zap4[i]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c1[i] <= sat32(66'(qpos[i]) - 66'(center[i]));
      p2[i] <= ax[i] * c1[i];
      c2[i] <= c1[i];
      c3[i] <= c2[i];
      zap4[i] <= z3 * ax[i];
      c4[i] <= c3[i];
      rv5[i] <= sat32(66'(c4[i]) - zr[i]);
      za5[i] <= zr[i][33:0];
      c5[i] <= c4[i];
      rq6[i] <= rv5[i] * rv5[i];
      cq6[i] <= c5[i] * c5[i];
      rv6[i] <= rv5[i];
      za6[i] <= za5[i];
      c6[i] <= c5[i];
    end
    z3 <= sat32(rnd16(66'(p2[0]) + 66'(p2[1]) + 66'(p2[2])));
    z4 <= z3;
    z5 <= z4;
    z6 <= z5;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // radial length and center distance roots
  pa_t pa [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    pa[0].v <= rst ? 1'b0 : v6;
    pa[0].sr <= '{n: rq6[0] + rq6[1] + rq6[2], res: 64'd0};
    pa[0].sc <= '{n: cq6[0] + cq6[1] + cq6[2], res: 64'd0};
    pa[0].rv <= rv6;
    pa[0].za <= za6;
    pa[0].z <= z6;
    pa[0].c <= c6;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_pa
    always_ff @(posedge clk) begin
      if (rst) pa[k+1].v <= 1'b0;
      else pa[k+1] <= pa_step(pa[k], k);
    end
  end

  // core distance operands, radial products
  logic               v8, v9;
  logic [31:0]        r8, r9;
  logic [31:0]        cn8, cn9;
  logic signed [31:0] q8;
  logic signed [63:0] num8 [3];
  logic signed [49:0] fp8 [3];
  logic signed [31:0] rv8 [3], rv9 [3];
  logic signed [33:0] za8 [3], za9 [3];
  logic signed [31:0] z8;
  logic signed [31:0] c8 [3], c9 [3];
  logic [63:0]        qq9, zz9;
  logic signed [33:0] ft9 [3];
  logic [63:0]        mag9 [3];
  logic               neg9 [3];
  logic signed [65:0] fr [3];
  logic [31:0]        r_a;

  assign r_a = pa[SQRT_STEPS].sr.res[31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fr[i] = rnd16(66'(fp8[i]));
    end
  end

  always_ff @(posedge clk) begin
    r8 <= r_a;
    cn8 <= pa[SQRT_STEPS].sc.res[31:0];
    q8 <= sat32($signed({34'd0, r_a}) - $signed({35'd0, major_radius}));
    z8 <= pa[SQRT_STEPS].z;
    for (int i = 0; i < 3; i++) begin
      num8[i] <= pa[SQRT_STEPS].rv[i] * $signed({1'b0, major_radius});
      fp8[i] <= fb[i] * $signed({1'b0, major_radius});
      rv8[i] <= pa[SQRT_STEPS].rv[i];
      za8[i] <= pa[SQRT_STEPS].za[i];
      c8[i] <= pa[SQRT_STEPS].c[i];
      ft9[i] <= fr[i][33:0];
      neg9[i] <= num8[i] < 0;
      mag9[i] <= (num8[i] < 0) ? -num8[i] : num8[i];
      rv9[i] <= rv8[i];
      za9[i] <= za8[i];
      c9[i] <= c8[i];
    end
    qq9 <= q8 * q8;
    zz9 <= z8 * z8;
    r9 <= r8;
    cn9 <= cn8;
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v8 <= pa[SQRT_STEPS].v;
      v9 <= v8;
    end
  end

  // core distance root and radial divides
  pb_t pb [DIV_T_STEPS+1];

  always_ff @(posedge clk) begin
    pb[0].v <= rst ? 1'b0 : v9;
    pb[0].sq <= '{n: qq9 + zz9, res: 64'd0};
    pb[0].rem <= mag9;
    pb[0].quot <= '{default: '0};
    pb[0].neg <= neg9;
    pb[0].r <= r9;
    pb[0].cn <= cn9;
    pb[0].rv <= rv9;
    pb[0].za <= za9;
    pb[0].ft <= ft9;
    pb[0].c <= c9;
  end

  for (genvar k = 0; k < DIV_T_STEPS; k++) begin : g_pb
    always_ff @(posedge clk) begin
      if (rst) pb[k+1].v <= 1'b0;
      else pb[k+1] <= pb_step(pb[k], k);
    end
  end

  // distance, core offset vector
  logic               v11, v12, v13;
  logic signed [33:0] s11, s12, s13;
  logic signed [31:0] dist11, dist12, dist13;
  logic signed [33:0] t11 [3];
  logic signed [31:0] rv11 [3];
  logic signed [33:0] za11 [3];
  logic signed [31:0] c11 [3], c12 [3], c13 [3];
  logic [31:0]        cn11, cn12, cn13;
  logic signed [31:0] d12 [3], d13 [3];
  logic [63:0]        dq13 [3];
  logic signed [33:0] s_b;
  logic signed [33:0] tq [3];

  assign s_b = $signed({2'b00, pb[DIV_T_STEPS].sq.res[31:0]}) - $signed({3'b000, tube_radius});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tq[i] = $signed({2'b00, pb[DIV_T_STEPS].quot[i]});
    end
  end

  always_ff @(posedge clk) begin
    s11 <= s_b;
    dist11 <= sat32(direction_inward ? -66'(s_b) : 66'(s_b));
    cn11 <= pb[DIV_T_STEPS].cn;
    for (int i = 0; i < 3; i++) begin
      if (pb[DIV_T_STEPS].r != 32'd0) begin
        t11[i] <= pb[DIV_T_STEPS].neg[i] ? -tq[i] : tq[i];
      end else begin
        t11[i] <= pb[DIV_T_STEPS].ft[i];
      end
      rv11[i] <= pb[DIV_T_STEPS].rv[i];
      za11[i] <= pb[DIV_T_STEPS].za[i];
      c11[i] <= pb[DIV_T_STEPS].c[i];
      d12[i] <= sat32(66'(rv11[i]) - 66'(t11[i]) + 66'(za11[i]));
      c12[i] <= c11[i];
      dq13[i] <= d12[i] * d12[i];
      d13[i] <= d12[i];
      c13[i] <= c12[i];
    end
    s12 <= s11;
    s13 <= s12;
    dist12 <= dist11;
    dist13 <= dist12;
    cn12 <= cn11;
    cn13 <= cn12;
    if (rst) begin
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
    end else begin
      v11 <= pb[DIV_T_STEPS].v;
      v12 <= v11;
      v13 <= v12;
    end
  end

  // core offset length root
  pc_t pc [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    pc[0].v <= rst ? 1'b0 : v13;
    pc[0].sq <= '{n: dq13[0] + dq13[1] + dq13[2], res: 64'd0};
    pc[0].d <= d13;
    pc[0].s <= s13;
    pc[0].sdist <= dist13;
    pc[0].c <= c13;
    pc[0].cn <= cn13;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_pc
    always_ff @(posedge clk) begin
      if (rst) pc[k+1].v <= 1'b0;
      else pc[k+1] <= pc_step(pc[k], k);
    end
  end

  // vector numerators; on the core circle fall back to the center direction
  logic               v15;
  logic signed [65:0] prod15 [3];
  logic [31:0]        den15;
  logic               zero15;
  logic signed [31:0] dist15;
  logic [31:0]        dd_c;
  logic               use_d;
  logic signed [31:0] mx [3];
  logic signed [33:0] my [3];

  assign dd_c = pc[SQRT_STEPS].sq.res[31:0];
  assign use_d = dd_c != 32'd0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = use_d ? pc[SQRT_STEPS].d[i] : pc[SQRT_STEPS].sdist;
      my[i] = use_d ? pc[SQRT_STEPS].s : 34'(pc[SQRT_STEPS].c[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod15[i] <= mx[i] * my[i];
    end
    den15 <= use_d ? dd_c : pc[SQRT_STEPS].cn;
    zero15 <= !use_d && (pc[SQRT_STEPS].cn == 32'd0);
    dist15 <= pc[SQRT_STEPS].sdist;
    if (rst) v15 <= 1'b0;
    else v15 <= pc[SQRT_STEPS].v;
  end

  // vector divides
  pd_t pd [DIV_V_STEPS+1];
  logic signed [65:0] pmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pmag[i] = (prod15[i] < 0) ? -prod15[i] : prod15[i];
    end
  end

  always_ff @(posedge clk) begin
    pd[0].v <= rst ? 1'b0 : v15;
    for (int i = 0; i < 3; i++) begin
      pd[0].rem[i] <= pmag[i][63:0];
      pd[0].neg[i] <= prod15[i] < 0;
    end
    pd[0].quot <= '{default: '0};
    pd[0].den <= den15;
    pd[0].zero <= zero15;
    pd[0].sdist <= dist15;
  end

  for (genvar k = 0; k < DIV_V_STEPS; k++) begin : g_pd
    always_ff @(posedge clk) begin
      if (rst) pd[k+1].v <= 1'b0;
      else pd[k+1] <= pd_step(pd[k], k);
    end
  end

  // output register
  logic signed [33:0] vq [3];
  logic signed [31:0] vs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vq[i] = $signed({1'b0, pd[DIV_V_STEPS].quot[i]});
      if (pd[DIV_V_STEPS].neg[i]) vq[i] = -vq[i];
      vs[i] = pd[DIV_V_STEPS].zero ? 32'sd0 : sat32(66'(vq[i]));
    end
  end

  always_ff @(posedge clk) begin
    result.distance <= pd[DIV_V_STEPS].sdist;
    result.vec_x <= vs[0];
    result.vec_y <= vs[1];
    result.vec_z <= vs[2];
    if (rst) done <= 1'b0;
    else done <= pd[DIV_V_STEPS].v;
  end

endmodule
